// ===== design/bfc_pkg.sv =====
package bfc_pkg;

  // Brightness scale and PWM period
  localparam int LEVELS     = 10;
  localparam int PWM_PERIOD = 416;

  // Command opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET      = 2'd1;
  localparam logic [1:0] OP_FADE_OFF = 2'd2;
  localparam logic [1:0] OP_FADE_ON  = 2'd3;

  // Fade modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_OFF  = 2'd1;
  localparam logic [1:0] MODE_ON   = 2'd2;

  // Register indexes
  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_STEP     = 1'b1;

  // Reset values
  localparam logic [15:0] DURATION_RESET = 16'd500;
  localparam logic [9:0]  STEP_RESET     = 10'd10;
  localparam logic [3:0]  LEVEL_RESET    = (5 > LEVELS) ? 4'(LEVELS) : 4'd5;
  localparam logic [3:0]  TARGET_RESET   = (10 > LEVELS) ? 4'(LEVELS) : 4'd10;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] level;
  } bfc_in_t;

  typedef struct packed {
    logic [3:0] level_out;
    logic [8:0] compare_value;
    logic       fading;
  } bfc_out_t;

  // Step request to the arithmetic unit
  typedef struct packed {
    logic        start;
    logic        fade_on;
    logic [3:0]  factor;
    logic [15:0] elapsed;
    logic [9:0]  step;
    logic [15:0] duration;
  } fade_req_t;

  // Step result from the arithmetic unit
  typedef struct packed {
    logic        done;
    logic        finished;
    logic [3:0]  level;
    logic [15:0] elapsed;
  } fade_rsp_t;

  typedef logic [15:0][8:0] cmp_table_t;

  // Inverted PWM compare for each level code, built at elaboration
  function automatic cmp_table_t build_cmp_table();
    cmp_table_t tab;
    int lv;
    for (int i = 0; i < 16; i++) begin
      lv = (i > LEVELS) ? LEVELS : i;
      if (lv == 0) begin
        tab[i] = 9'(PWM_PERIOD);
      end else begin
        tab[i] = 9'(((LEVELS - lv) * PWM_PERIOD) / LEVELS);
      end
    end
    return tab;
  endfunction

  localparam cmp_table_t CMP_TABLE = build_cmp_table();

endpackage

// ===== design/bfc_fade_unit.sv =====
// One fade step: saturating elapsed update, then, unless the fade ends, factor*numerator by
// shift-add and /duration by restoring division, all on one shared adder.
module bfc_fade_unit (
  input  logic              clk,
  input  logic              rst,
  input  bfc_pkg::fade_req_t req,
  output bfc_pkg::fade_rsp_t rsp
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_ELAP = 3'd1;
  localparam logic [2:0] U_PREP = 3'd2;
  localparam logic [2:0] U_MUL  = 3'd3;
  localparam logic [2:0] U_DIV  = 3'd4;
  localparam logic [2:0] U_DONE = 3'd5;

  logic [2:0]  state;
  logic        on_r;
  logic [3:0]  factor_r;
  logic [15:0] dur_r;
  logic [9:0]  step_r;
  logic [15:0] e_r;
  logic [15:0] mcand;
  logic [19:0] acc;
  logic [3:0]  q;
  logic [1:0]  k;
  logic        finished;

  logic [20:0] opa;
  logic [20:0] opb;
  logic        sub;
  logic [20:0] sum;
  logic        sat;

  // Shared adder operand select
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (state)
      U_ELAP: begin
        opa = {5'b0, e_r};
        opb = {11'b0, step_r};
      end
      U_PREP: begin
        opa = {5'b0, dur_r};
        opb = {5'b0, e_r};
        sub = 1'b1;
      end
      U_MUL: begin
        opa = {1'b0, acc};
        opb = factor_r[k] ? ({5'b0, mcand} << k) : '0;
      end
      U_DIV: begin
        opa = {1'b0, acc};
        opb = {5'b0, dur_r} << k;
        sub = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign sum = opa + (sub ? ~opb : opb) + {20'b0, sub};
  assign sat = (sum >= {5'b0, dur_r});

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      unique case (state)
        U_IDLE: begin
          if (req.start) begin
            on_r     <= req.fade_on;
            factor_r <= req.factor;
            dur_r    <= req.duration;
            step_r   <= req.step;
            e_r      <= req.elapsed;
            state    <= U_ELAP;
          end
        end
        U_ELAP: begin
          e_r      <= sat ? dur_r : sum[15:0];
          finished <= sat;
          state    <= sat ? U_DONE : U_PREP;
        end
        U_PREP: begin
          mcand <= on_r ? e_r : sum[15:0];
          acc   <= '0;
          q     <= '0;
          k     <= 2'd0;
          state <= U_MUL;
        end
        U_MUL: begin
          acc <= sum[19:0];
          if (k == 2'd3) begin
            state <= U_DIV;
          end else begin
            k <= k + 2'd1;
          end
        end
        U_DIV: begin
          if (!sum[20]) begin
            acc  <= sum[19:0];
            q[k] <= 1'b1;
          end
          k <= k - 2'd1;
          if (k == 2'd0) begin
            state <= U_DONE;
          end
        end
        U_DONE: begin
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = (state == U_DONE);
  assign rsp.finished = finished;
  assign rsp.elapsed  = e_r;
  assign rsp.level    = finished ? (on_r ? factor_r : 4'd0) : q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == U_IDLE)
    else $error("step request while unit busy");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.level <= factor_r)
    else $error("step level above its scale factor");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.elapsed <= dur_r)
    else $error("elapsed time past duration");
`endif

endmodule

// ===== design/backlight_fade_controller_unit.sv =====
// Channel  Signals                          Beat
// -------  -------------------------------  --------------------------------
// in       in_valid/in_ready, in_data       one command: opcode, level
// out      out_valid/out_ready, out_data    level, PWM compare, fading flag
// cfg      cfg_wr_en, cfg_addr, cfg_wdata   register write, no handshake
//
// A tick that makes a fade step waits in T_WAIT on bfc_fade_unit, which runs the
// elapsed update and then the shift-add/divide iterations of its shared adder
// (only the update when the step ends the fade); every other command goes to T_EMIT.
// One command is in work at a time; in_ready drops from accept until the
// result sits in the output register, which then waits on out_ready.
// Synchronous active-high reset; no clearing pass.
module backlight_fade_controller_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfc_pkg::bfc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bfc_pkg::bfc_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_WAIT = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0]  state;
  logic [15:0] fade_len;
  logic [9:0]  step_ms;
  logic [1:0]  fade_mode;
  logic [3:0]  level_now;
  logic [3:0]  fade_start_level;
  logic [3:0]  fade_target;
  logic [15:0] elapsed_time;
  logic [9:0]  ticks_since_step;
  logic        first_step_pending;

  logic               accept;
  logic [3:0]         lv_clamped;
  logic [9:0]         step_eff;
  logic [9:0]         ticks_inc;
  logic               do_step;
  logic               emit_load;
  bfc_pkg::fade_req_t req;
  bfc_pkg::fade_rsp_t rsp;

  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_load = (state == T_EMIT) && (!out_valid || out_ready);

  // Input level clamp and tick bookkeeping
  assign lv_clamped = (in_data.level > 4'(bfc_pkg::LEVELS)) ? 4'(bfc_pkg::LEVELS)
                                                             : in_data.level;
  assign step_eff   = (step_ms == 10'd0) ? 10'd1 : step_ms;
  assign ticks_inc  = (&ticks_since_step) ? ticks_since_step : ticks_since_step + 10'd1;
  assign do_step    = first_step_pending || (ticks_inc >= step_eff);

  // Step request
  assign req.start    = accept && (in_data.opcode == bfc_pkg::OP_TICK) &&
                        (fade_mode != bfc_pkg::MODE_IDLE) && do_step;
  assign req.fade_on  = (fade_mode == bfc_pkg::MODE_ON);
  assign req.factor   = (fade_mode == bfc_pkg::MODE_ON) ? fade_target : fade_start_level;
  assign req.elapsed  = elapsed_time;
  assign req.step     = step_eff;
  assign req.duration = fade_len;

  bfc_fade_unit u_fade (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_len <= bfc_pkg::DURATION_RESET;
      step_ms  <= bfc_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bfc_pkg::REG_DURATION: fade_len <= cfg_wdata;
        bfc_pkg::REG_STEP:     step_ms  <= cfg_wdata[9:0];
        default:               fade_len <= fade_len;
      endcase
    end
  end

  // Command sequencer and fade state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= T_IDLE;
      fade_mode          <= bfc_pkg::MODE_IDLE;
      level_now          <= bfc_pkg::LEVEL_RESET;
      fade_start_level   <= bfc_pkg::LEVEL_RESET;
      fade_target        <= bfc_pkg::TARGET_RESET;
      elapsed_time       <= '0;
      ticks_since_step   <= '0;
      first_step_pending <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            // a stepping tick waits on the fade unit, all else goes straight out
            state <= req.start ? T_WAIT : T_EMIT;
            unique case (in_data.opcode)
              bfc_pkg::OP_TICK: begin
                if (fade_mode != bfc_pkg::MODE_IDLE) begin
                  first_step_pending <= 1'b0;
                  ticks_since_step   <= do_step ? 10'd0 : ticks_inc;
                end
              end
              bfc_pkg::OP_SET: begin
                level_now <= lv_clamped;
                fade_mode <= bfc_pkg::MODE_IDLE;
              end
              bfc_pkg::OP_FADE_OFF: begin
                fade_mode          <= bfc_pkg::MODE_OFF;
                fade_start_level   <= level_now;
                fade_target        <= 4'd0;
                elapsed_time       <= '0;
                ticks_since_step   <= '0;
                first_step_pending <= 1'b1;
              end
              bfc_pkg::OP_FADE_ON: begin
                fade_mode          <= bfc_pkg::MODE_ON;
                fade_target        <= lv_clamped;
                elapsed_time       <= '0;
                ticks_since_step   <= '0;
                first_step_pending <= 1'b1;
              end
            endcase
          end
        end
        T_WAIT: begin
          if (rsp.done) begin
            level_now    <= rsp.level;
            elapsed_time <= rsp.elapsed;
            if (rsp.finished) begin
              fade_mode <= bfc_pkg::MODE_IDLE;
            end
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (emit_load) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data.level_out     <= level_now;
      out_data.compare_value <= bfc_pkg::CMP_TABLE[level_now];
      out_data.fading        <= (fade_mode != bfc_pkg::MODE_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == T_WAIT)
    else $error("step result outside wait state");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level_now <= 4'(bfc_pkg::LEVELS))
    else $error("level beyond scale");

  a_wait_fading: assert property (@(posedge clk) disable iff (rst)
    state == T_WAIT |-> fade_mode != bfc_pkg::MODE_IDLE)
    else $error("step in flight with no fade active");
`endif

endmodule
